@@ src/raq_pkg.sv @@
// ----------------------------------------------------------------------------
// raq_pkg
// Shared constants and element conversion functions for the row
// absmax weight quantizer.
// ----------------------------------------------------------------------------
package raq_pkg;

  localparam int unsigned MAX_COLS_DEF = 512;

  localparam int unsigned CFG_INDEX_W = 4;
  localparam int unsigned CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_FORMAT = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NIBBLE_MODE   = 4'd1;

  localparam logic [1:0] SRC_FP32 = 2'd0;
  localparam logic [1:0] SRC_FP16 = 2'd1;
  localparam logic [1:0] SRC_BF16 = 2'd2;

  localparam logic [31:0] F32_ONE     = 32'h3F80_0000;
  localparam logic [31:0] F32_SEVEN   = 32'h40E0_0000;
  localparam logic [31:0] F32_127     = 32'h42FE_0000;
  localparam logic [31:0] F32_INF     = 32'h7F80_0000;
  localparam logic [31:0] SCALE_FLOOR = 32'h3880_029A;
  localparam logic [15:0] HALF_INF    = 16'h7C00;

  localparam logic [7:0] LIM_INT8 = 8'd127;
  localparam logic [7:0] LIM_INT4 = 8'd7;
  localparam logic [3:0] NIB_BIAS = 4'd8;

  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic       sgn;
    logic [4:0] e;
    logic [9:0] m;
    logic [3:0] p;
    logic [9:0] mn;
    logic [7:0] ef;
    begin
      sgn = h[15];
      e   = h[14:10];
      m   = h[9:0];
      p   = 4'd0;
      for (int i = 0; i < 10; i++) begin
        if (m[i]) p = 4'(i);
      end
      mn = m << (4'd10 - p);
      ef = 8'd103 + {4'b0, p};
      if (e == 5'd0) begin
        if (m == 10'd0) half_to_single = {sgn, 31'b0};
        else half_to_single = {sgn, ef, mn, 13'b0};
      end else if (e == 5'h1F) begin
        half_to_single = {sgn, 8'hFF, m, 13'b0};
      end else begin
        half_to_single = {sgn, {3'b0, e} + 8'd112, m, 13'b0};
      end
    end
  endfunction

  function automatic logic [31:0] decode_element(input logic [31:0] bits,
                                                 input logic [1:0] fmt);
    begin
      case (fmt)
        SRC_FP16: decode_element = half_to_single(bits[15:0]);
        SRC_BF16: decode_element = {bits[15:0], 16'b0};
        default:  decode_element = bits;
      endcase
    end
  endfunction

  // positive scale only; truncates, flushes small values, saturates large ones to infinity
  function automatic logic [15:0] single_to_half(input logic [31:0] b);
    logic [7:0] ex;
    logic [7:0] eh;
    begin
      ex = b[30:23];
      eh = ex - 8'd112;
      if (ex <= 8'd112) single_to_half = 16'h0000;
      else if (ex >= 8'd143) single_to_half = HALF_INF;
      else single_to_half = {1'b0, eh[4:0], b[22:13]};
    end
  endfunction

endpackage

@@ src/raq_if.sv @@
// ----------------------------------------------------------------------------
// raq_if
// Valid/ready channels of the row absmax weight quantizer.
// ----------------------------------------------------------------------------
interface raq_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] element_bits;
  logic        row_end;
  modport source(output valid, element_bits, row_end, input ready);
  modport sink(input valid, element_bits, row_end, output ready);
endinterface

interface raq_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  logic [15:0] scale_bits;
  logic        last_of_row;
  logic        overflow;
  modport source(output valid, data_word, byte_count, scale_bits, last_of_row, overflow,
                 input ready);
  modport sink(input valid, data_word, byte_count, scale_bits, last_of_row, overflow,
               output ready);
endinterface

interface raq_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [raq_pkg::CFG_INDEX_W-1:0]    index;
  logic [raq_pkg::CFG_DATA_W-1:0]     data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ src/row_absmax_weight_quantizer_top.sv @@
// ----------------------------------------------------------------------------
// row_absmax_weight_quantizer_top
// Per-row symmetric absmax quantizer to INT8 or biased packed INT4.
// ----------------------------------------------------------------------------
// Usage:
//   elem_ch takes one source element per transfer (FP32, FP16 or BF16 as
//   set by source_format); row_end closes the row. Elements are widened to
//   binary32 and written to a single-port row memory while the largest
//   magnitude is tracked. Elements past MAX_COLS are dropped and flagged.
//   At row end elem_ch drops ready. One iterative divider forms max/127 or
//   max/7 (skipped for a zero max) and then 1/scale (both skipped for an
//   infinite max). The row memory is then read back through a multiply and
//   round pipeline, 8 (INT8) or 16 (INT4) elements per output word, and
//   each word is offered on word_ch. Throughput: one element per cycle
//   while a row streams in; after row end no element is taken until the
//   row's last word has left on word_ch. A stalled word is held in the
//   output register until its transfer. cfg_ch is always ready; the user
//   must write it only between rows; the block does not enforce this.
//   Reset (rst, synchronous) empties the row, sets source_format to FP16
//   and nibble_mode to INT8; row memory contents need no clearing.
// ----------------------------------------------------------------------------
module row_absmax_weight_quantizer_top #(
  parameter int unsigned MAX_COLS = raq_pkg::MAX_COLS_DEF
) (
  input logic       clk,
  input logic       rst,
  raq_in_if.sink    elem_ch,
  raq_out_if.source word_ch,
  raq_cfg_if.sink   cfg_ch
);

  localparam int unsigned AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned CW = $clog2(MAX_COLS + 1);

  typedef enum logic [3:0] {
    S_COLLECT, S_SCALE, S_DIV_A, S_INV, S_DIV_B, S_WORD, S_FILL, S_PAD, S_OUT
  } state_t;

  state_t          state;
  logic [1:0]      src_fmt;
  logic            nib_cfg;
  logic [CW-1:0]   count;
  logic [31:0]     max_mag;
  logic            ovf;
  logic            nib_row;
  logic            zero_all;
  logic [31:0]     scale;
  logic [31:0]     inv;
  logic [CW-1:0]   base;
  logic [4:0]      welems;
  logic            wlast;
  logic [4:0]      iss;
  logic [4:0]      ret;
  logic [63:0]     wordbuf;

  logic [31:0]     row_mem [MAX_COLS];
  logic [31:0]     rd_data;

  // divider
  logic [24:0]     dv_rem;
  logic [24:0]     dv_quo;
  logic [23:0]     dv_mb;
  logic [4:0]      dv_iter;
  logic [9:0]      dv_exp;

  // pipeline
  logic            p1_vld;
  logic [3:0]      p1_slot;
  logic            pb_vld;
  logic [3:0]      pb_slot;
  logic [47:0]     pb_prod;
  logic [8:0]      pb_esum;
  logic            pb_neg;
  logic            pb_zero;
  logic            pc_vld;
  logic [3:0]      pc_slot;
  logic [7:0]      pc_q;

  // output register
  logic            out_vld;
  logic [63:0]     out_data;
  logic [3:0]      out_cnt;
  logic [15:0]     out_scale;
  logic            out_last;
  logic            out_ovf;

  // ---------------- input side ----------------
  logic        elem_fire;
  logic [31:0] dec;
  logic [31:0] mag;
  logic        mag_nan;
  logic        room;
  logic        wr_en;

  assign elem_ch.ready = (state == S_COLLECT);
  assign elem_fire     = elem_ch.valid && elem_ch.ready;
  assign dec           = raq_pkg::decode_element(elem_ch.element_bits, src_fmt);
  assign mag           = {1'b0, dec[30:0]};
  assign mag_nan       = (mag[30:23] == 8'hFF) && (mag[22:0] != 23'd0);
  assign room          = count < CW'(MAX_COLS);
  assign wr_en         = elem_fire && room;

  // ---------------- memory ----------------
  logic          rd_en;
  logic [CW:0]   addr_sum;
  logic [AW-1:0] rd_addr;

  assign rd_en    = (state == S_FILL) && (iss < welems);
  assign addr_sum = {1'b0, base} + (CW+1)'(iss);
  assign rd_addr  = addr_sum[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) row_mem[count[AW-1:0]] <= dec;
    if (rd_en) rd_data <= row_mem[rd_addr];
  end

  // ---------------- divider ----------------
  logic [31:0] dl_a;
  logic [31:0] dl_b;
  logic [23:0] dl_ma;
  logic [23:0] dl_mb;
  logic        dl_ge;
  logic        dv_ge;
  logic [24:0] dv_sub;
  logic [23:0] dv_man;
  logic        dv_rnd;
  logic [24:0] dv_sum;
  logic [9:0]  dv_exp_r;
  logic [31:0] dv_bits;
  logic [31:0] res_a;

  assign dl_a   = (state == S_SCALE) ? max_mag : raq_pkg::F32_ONE;
  assign dl_b   = (state == S_SCALE) ? (nib_row ? raq_pkg::F32_SEVEN : raq_pkg::F32_127)
                                     : scale;
  assign dl_ma  = {1'b1, dl_a[22:0]};
  assign dl_mb  = {1'b1, dl_b[22:0]};
  assign dl_ge  = dl_ma >= dl_mb;

  assign dv_ge  = dv_rem >= {1'b0, dv_mb};
  assign dv_sub = dv_ge ? (dv_rem - {1'b0, dv_mb}) : dv_rem;

  assign dv_man   = dv_quo[24:1];
  assign dv_rnd   = dv_quo[0] && ((dv_rem != 25'd0) || dv_quo[1]);
  assign dv_sum   = {1'b0, dv_man} + 25'(dv_rnd);
  assign dv_exp_r = dv_exp + 10'(dv_sum[24]);
  assign dv_bits  = {1'b0, dv_exp_r[7:0], dv_sum[24] ? 23'd0 : dv_sum[22:0]};
  assign res_a    = ($signed(dv_exp_r) <= 10'sd0 || dv_bits < raq_pkg::SCALE_FLOOR)
                    ? raq_pkg::SCALE_FLOOR : dv_bits;

  // ---------------- quantize stage ----------------
  logic        qc_hi;
  logic [23:0] qc_m;
  logic        qc_g;
  logic        qc_s;
  logic [24:0] qc_mr;
  logic [10:0] qc_sh;
  logic [27:0] qc_tsum;
  logic [7:0]  qc_lim;
  logic [7:0]  qc_t;
  logic [7:0]  qc_q;

  always_comb begin
    qc_hi   = pb_prod[47];
    qc_m    = qc_hi ? pb_prod[47:24] : pb_prod[46:23];
    qc_g    = qc_hi ? pb_prod[23] : pb_prod[22];
    qc_s    = qc_hi ? (|pb_prod[22:0]) : (|pb_prod[21:0]);
    qc_mr   = {1'b0, qc_m} + 25'(qc_g && (qc_s || qc_m[0]));
    qc_sh   = (qc_hi ? 11'd276 : 11'd277) - {2'b0, pb_esum};
    qc_lim  = nib_row ? raq_pkg::LIM_INT4 : raq_pkg::LIM_INT8;
    qc_tsum = ({2'b0, qc_mr, 1'b0} + (28'd1 << qc_sh[4:0])) >> (qc_sh[4:0] + 5'd1);
    if (pb_zero) begin
      qc_t = 8'd0;
    end else if ($signed(qc_sh) < 11'sd0) begin
      qc_t = qc_lim;
    end else if ($signed(qc_sh) > 11'sd25) begin
      qc_t = 8'd0;
    end else if (qc_tsum > 28'(qc_lim)) begin
      qc_t = qc_lim;
    end else begin
      qc_t = qc_tsum[7:0];
    end
    qc_q = pb_neg ? (8'd0 - qc_t) : qc_t;
  end

  // ---------------- word sizing ----------------
  logic [CW-1:0] remain;
  logic [CW+4:0] remain_w;
  logic [CW+4:0] epw_w;
  logic [63:0]   pad_word;
  logic [3:0]    byte_cnt;
  logic [4:0]    half_up;

  assign remain   = count - base;
  assign remain_w = (CW+5)'(remain);
  assign epw_w    = nib_row ? (CW+5)'(16) : (CW+5)'(8);
  assign half_up  = (welems + 5'd1) >> 1;
  assign byte_cnt = nib_row ? half_up[3:0] : welems[3:0];

  always_comb begin
    pad_word = wordbuf;
    if (nib_row && welems[0]) pad_word[{welems[3:0], 2'b00} +: 4] = raq_pkg::NIB_BIAS;
  end

  // ---------------- configuration ----------------
  logic cfg_fire;
  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;

  // ---------------- control ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_COLLECT;
      src_fmt  <= raq_pkg::SRC_FP16;
      nib_cfg  <= 1'b0;
      count    <= '0;
      max_mag  <= '0;
      ovf      <= 1'b0;
      nib_row  <= 1'b0;
      zero_all <= 1'b0;
      base     <= '0;
      iss      <= '0;
      ret      <= '0;
      dv_iter  <= '0;
      p1_vld   <= 1'b0;
      pb_vld   <= 1'b0;
      pc_vld   <= 1'b0;
      out_vld  <= 1'b0;
    end else begin
      if (cfg_fire) begin
        unique case (cfg_ch.index)
          raq_pkg::REG_SOURCE_FORMAT: src_fmt <= cfg_ch.data[1:0];
          raq_pkg::REG_NIBBLE_MODE:   nib_cfg <= cfg_ch.data[0];
          default: ;
        endcase
      end

      p1_vld  <= rd_en;
      p1_slot <= iss[3:0];
      pb_vld  <= p1_vld;
      pb_slot <= p1_slot;
      pb_prod <= {1'b1, rd_data[22:0]} * {1'b1, inv[22:0]};
      pb_esum <= {1'b0, rd_data[30:23]} + {1'b0, inv[30:23]};
      pb_neg  <= rd_data[31];
      pb_zero <= zero_all || (rd_data[30:23] == 8'd0) || (rd_data[30:23] == 8'hFF);
      pc_vld  <= pb_vld;
      pc_slot <= pb_slot;
      pc_q    <= qc_q;

      unique case (state)
        S_COLLECT: begin
          if (elem_fire) begin
            if (room) begin
              count <= count + CW'(1);
              if (!mag_nan && mag > max_mag) max_mag <= mag;
            end else begin
              ovf <= 1'b1;
            end
            if (elem_ch.row_end) begin
              nib_row <= nib_cfg;
              state   <= S_SCALE;
            end
          end
        end
        S_SCALE: begin
          if (max_mag[30:23] == 8'd0) begin
            scale <= raq_pkg::SCALE_FLOOR;
            state <= S_INV;
          end else if (max_mag[30:23] == 8'hFF) begin
            scale    <= raq_pkg::F32_INF;
            zero_all <= 1'b1;
            state    <= S_WORD;
          end else begin
            dv_rem  <= dl_ge ? {1'b0, dl_ma} : {dl_ma, 1'b0};
            dv_mb   <= dl_mb;
            dv_exp  <= {2'b0, dl_a[30:23]} - {2'b0, dl_b[30:23]} + (dl_ge ? 10'd127 : 10'd126);
            dv_iter <= '0;
            state   <= S_DIV_A;
          end
        end
        S_INV: begin
          dv_rem  <= dl_ge ? {1'b0, dl_ma} : {dl_ma, 1'b0};
          dv_mb   <= dl_mb;
          dv_exp  <= {2'b0, dl_a[30:23]} - {2'b0, dl_b[30:23]} + (dl_ge ? 10'd127 : 10'd126);
          dv_iter <= '0;
          state   <= S_DIV_B;
        end
        S_DIV_A, S_DIV_B: begin
          if (dv_iter != 5'd25) begin
            dv_rem  <= {dv_sub[23:0], 1'b0};
            dv_quo  <= {dv_quo[23:0], dv_ge};
            dv_iter <= dv_iter + 5'd1;
          end else if (state == S_DIV_A) begin
            scale <= res_a;
            state <= S_INV;
          end else begin
            inv   <= dv_bits;
            state <= S_WORD;
          end
        end
        S_WORD: begin
          welems  <= (remain_w >= epw_w) ? epw_w[4:0] : remain_w[4:0];
          wlast   <= remain_w <= epw_w;
          iss     <= '0;
          ret     <= '0;
          wordbuf <= '0;
          state   <= S_FILL;
        end
        S_FILL: begin
          if (rd_en) iss <= iss + 5'd1;
          if (pc_vld) begin
            ret <= ret + 5'd1;
            if (nib_row) wordbuf[{pc_slot, 2'b00} +: 4] <= pc_q[3:0] + raq_pkg::NIB_BIAS;
            else wordbuf[{pc_slot[2:0], 3'b000} +: 8] <= pc_q;
          end
          if (ret == welems) state <= S_PAD;
        end
        S_PAD: begin
          out_vld   <= 1'b1;
          out_data  <= pad_word;
          out_cnt   <= byte_cnt;
          out_scale <= raq_pkg::single_to_half(scale);
          out_last  <= wlast;
          out_ovf   <= ovf;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (word_ch.ready) begin
            out_vld <= 1'b0;
            if (out_last) begin
              count    <= '0;
              max_mag  <= '0;
              ovf      <= 1'b0;
              zero_all <= 1'b0;
              base     <= '0;
              state    <= S_COLLECT;
            end else begin
              base  <= base + CW'(welems);
              state <= S_WORD;
            end
          end
        end
        default: state <= S_COLLECT;
      endcase
    end
  end

  assign word_ch.valid       = out_vld;
  assign word_ch.data_word   = out_data;
  assign word_ch.byte_count  = out_cnt;
  assign word_ch.scale_bits  = out_scale;
  assign word_ch.last_of_row = out_last;
  assign word_ch.overflow    = out_ovf;

endmodule
